/* hw/rtl/e2q_pkg.sv */
// Package with shared constants, types and tables for the Euler-to-quaternion unit.
`default_nettype none
package e2q_pkg;
  localparam int ANG_W = 18;
  localparam int OUT_W = 16;
  localparam int TRIG_W = 22;
  localparam int PAIR_W = 2 * TRIG_W;
  localparam int LO_W = 21;
  localparam int HI_W = PAIR_W - LO_W;
  localparam int SUM_W = 64;
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_FIRST = 5;
  localparam int SC_STAGES = CORDIC_FIRST + CORDIC_STEPS + 1;
  localparam int N_STAGES = SC_STAGES + 5;
  localparam int XY_W = 34;
  localparam int Z_W = 33;
  localparam int RSH = 3 * 20 - 15;
  localparam logic [18:0] RECIP_A = 19'd372828;
  localparam logic [26:0] RECIP_B = 27'd95443718;
  localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sd652032875;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sd32767;

  typedef logic [N_STAGES-1:0] stage_en_t;

  function automatic logic signed [Z_W-1:0] atan_turns(input int idx);
    logic signed [Z_W-1:0] v;
    begin
      case (idx)
        0: v = 33'sd536870912;
        1: v = 33'sd316933406;
        2: v = 33'sd167458907;
        3: v = 33'sd85004756;
        4: v = 33'sd42667331;
        5: v = 33'sd21354465;
        6: v = 33'sd10679838;
        7: v = 33'sd5340245;
        8: v = 33'sd2670163;
        9: v = 33'sd1335087;
        10: v = 33'sd667544;
        11: v = 33'sd333772;
        12: v = 33'sd166886;
        13: v = 33'sd83443;
        14: v = 33'sd41722;
        15: v = 33'sd20861;
        16: v = 33'sd10430;
        17: v = 33'sd5215;
        18: v = 33'sd2608;
        19: v = 33'sd1304;
        20: v = 33'sd652;
        21: v = 33'sd326;
        22: v = 33'sd163;
        23: v = 33'sd81;
        default: v = '0;
      endcase
      return v;
    end
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/e2q_sincos.sv */
// Pipelined half-angle sine and cosine of one angle: phase scaling, quadrant fold, CORDIC.
`default_nettype none
module e2q_sincos (
  input  wire logic clk,
  input  wire logic [e2q_pkg::SC_STAGES-1:0] en,
  input  wire logic signed [e2q_pkg::ANG_W-1:0] angle,
  output logic signed [e2q_pkg::TRIG_W-1:0] cos_h,
  output logic signed [e2q_pkg::TRIG_W-1:0] sin_h
);
  localparam int XY_W = e2q_pkg::XY_W;
  localparam int Z_W = e2q_pkg::Z_W;
  localparam int NS = e2q_pkg::CORDIC_STEPS;

  logic signed [e2q_pkg::ANG_W-1:0] ang0;
  logic [17:0] mag1;
  logic neg1, neg2, neg3;
  logic [11:0] qm1, qm2, qm3;
  logic [25:0] v2;
  logic [19:0] q3;
  logic [17:0] mag_c;
  logic [36:0] prod_a;
  logic [5:0] rm_c;
  logic [52:0] prod_b;
  logic [31:0] ph_c, phn_c, phf_c;
  logic flip_c;

  logic signed [XY_W-1:0] x [0:NS];
  logic signed [XY_W-1:0] y [0:NS];
  logic signed [Z_W-1:0] z [0:NS];
  logic flip [0:NS];
  logic signed [XY_W-1:0] xr_c, yr_c;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ang0 <= angle;
    end
  end

  assign mag_c = ang0[e2q_pkg::ANG_W-1] ? 18'(-ang0) : 18'(ang0);
  assign prod_a = mag_c * e2q_pkg::RECIP_A;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mag1 <= mag_c;
      neg1 <= ang0[e2q_pkg::ANG_W-1];
      qm1 <= prod_a[35:24];
    end
  end

  assign rm_c = 6'(mag1 - 18'(qm1) * 18'd45);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      v2 <= {rm_c, 20'd0} + 26'd22;
      qm2 <= qm1;
      neg2 <= neg1;
    end
  end

  assign prod_b = v2 * e2q_pkg::RECIP_B;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      q3 <= prod_b[51:32];
      qm3 <= qm2;
      neg3 <= neg2;
    end
  end

  always_comb begin
    ph_c = {qm3, 20'd0} + {12'd0, q3};
    phn_c = neg3 ? (32'd0 - ph_c) : ph_c;
    flip_c = (phn_c[31:30] == 2'd1) || (phn_c[31:30] == 2'd2);
    phf_c = flip_c ? (phn_c - 32'h8000_0000) : phn_c;
  end

  assign x[0] = e2q_pkg::CORDIC_X0;
  assign y[0] = '0;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      z[0] <= Z_W'(signed'(phf_c));
      flip[0] <= flip_c;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    logic signed [XY_W-1:0] dx, dy;
    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;
    always_ff @(posedge clk) begin
      if (en[e2q_pkg::CORDIC_FIRST + i]) begin
        if (!z[i][Z_W-1]) begin
          x[i+1] <= x[i] - dx;
          y[i+1] <= y[i] + dy;
          z[i+1] <= z[i] - e2q_pkg::atan_turns(i);
        end else begin
          x[i+1] <= x[i] + dx;
          y[i+1] <= y[i] - dy;
          z[i+1] <= z[i] + e2q_pkg::atan_turns(i);
        end
        flip[i+1] <= flip[i];
      end
    end
  end

  assign xr_c = (x[NS] + XY_W'(512)) >>> 10;
  assign yr_c = (y[NS] + XY_W'(512)) >>> 10;

  always_ff @(posedge clk) begin
    if (en[e2q_pkg::SC_STAGES-1]) begin
      cos_h <= flip[NS] ? -xr_c[e2q_pkg::TRIG_W-1:0] : xr_c[e2q_pkg::TRIG_W-1:0];
      sin_h <= flip[NS] ? -yr_c[e2q_pkg::TRIG_W-1:0] : yr_c[e2q_pkg::TRIG_W-1:0];
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/euler_to_quaternion_unit.sv */
// Top level: converts yaw, pitch and roll to a Q1.15 quaternion in a stallable pipeline.
// Usage:
// A request carries pitch_deg, yaw_deg and roll_deg, signed degrees with 8
// fraction bits; it is taken at a clock edge with req_valid high and req_stall low.
// The result channel presents quat_w, quat_x, quat_y and quat_z as Q1.15
// values saturated to +-32767, handed over when res_valid is high and
// res_stall is low. Exactly one result leaves for each request, in order.
// A request passes through 35 register stages on its way to res_valid:
// the 30-stage half-angle sine/cosine pipeline (phase scaling, quadrant
// fold and 24 CORDIC steps) and five stages of products, sums and rounding.
// Throughput is one request per cycle while req_stall stays low; each stage holds
// its own valid bit, so when the receiver stalls the pipeline keeps filling its
// empty stages and req_stall rises only once the stage in front of the input is held.
// Synchronous reset clears all valid bits; no result is lost or repeated.
`default_nettype none
module euler_to_quaternion_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic req_stall,
  input  wire logic signed [17:0] pitch_deg,
  input  wire logic signed [17:0] yaw_deg,
  input  wire logic signed [17:0] roll_deg,
  output logic res_valid,
  input  wire logic res_stall,
  output logic signed [15:0] quat_w,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z
);
  localparam int NST = e2q_pkg::N_STAGES;
  localparam int SCS = e2q_pkg::SC_STAGES;
  localparam int TW = e2q_pkg::TRIG_W;
  localparam int PW = e2q_pkg::PAIR_W;
  localparam int LW = e2q_pkg::LO_W;
  localparam int HW = e2q_pkg::HI_W;
  localparam int SW = e2q_pkg::SUM_W;

  logic [NST-1:0] vld;
  logic [NST:0] rdy;
  e2q_pkg::stage_en_t en;

  assign rdy[NST] = !res_stall;
  for (genvar k = 0; k < NST; k++) begin : g_ctl
    assign rdy[k] = !vld[k] || rdy[k+1];
    if (k == 0) begin : g_first
      assign en[k] = rdy[k] && req_valid;
    end else begin : g_rest
      assign en[k] = rdy[k] && vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= req_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign req_stall = !rdy[0];
  assign res_valid = vld[NST-1];

  logic signed [TW-1:0] cx, sx, cy, sy, cz, sz;

  e2q_sincos u_pitch (.clk(clk), .en(en[SCS-1:0]), .angle(pitch_deg), .cos_h(cx), .sin_h(sx));
  e2q_sincos u_yaw (.clk(clk), .en(en[SCS-1:0]), .angle(yaw_deg), .cos_h(cy), .sin_h(sy));
  e2q_sincos u_roll (.clk(clk), .en(en[SCS-1:0]), .angle(roll_deg), .cos_h(cz), .sin_h(sz));

  logic signed [PW-1:0] pr [0:3];
  logic signed [TW-1:0] cz1, sz1;

  always_ff @(posedge clk) begin
    if (en[SCS]) begin
      pr[0] <= cy * cx;
      pr[1] <= sy * sx;
      pr[2] <= cy * sx;
      pr[3] <= sy * cx;
      cz1 <= cz;
      sz1 <= sz;
    end
  end

  logic signed [HW+TW-1:0] hp [0:7];
  logic signed [LW+TW:0] lp [0:7];
  logic signed [SW-1:0] tp [0:7];

  for (genvar t = 0; t < 8; t++) begin : g_trip
    logic signed [PW-1:0] pa;
    logic signed [TW-1:0] fb;
    logic signed [HW-1:0] ph;
    logic signed [LW:0] pl;
    always_comb begin
      case (t)
        0: begin pa = pr[0]; fb = cz1; end
        1: begin pa = pr[1]; fb = sz1; end
        2: begin pa = pr[2]; fb = cz1; end
        3: begin pa = pr[3]; fb = sz1; end
        4: begin pa = pr[3]; fb = cz1; end
        5: begin pa = pr[2]; fb = sz1; end
        6: begin pa = pr[0]; fb = sz1; end
        default: begin pa = pr[1]; fb = cz1; end
      endcase
    end
    assign ph = pa[PW-1:LW];
    assign pl = signed'({1'b0, pa[LW-1:0]});
    always_ff @(posedge clk) begin
      if (en[SCS+1]) begin
        hp[t] <= ph * fb;
        lp[t] <= pl * fb;
      end
    end
    always_ff @(posedge clk) begin
      if (en[SCS+2]) begin
        tp[t] <= (SW'(hp[t]) <<< LW) + SW'(lp[t]);
      end
    end
  end

  logic signed [SW-1:0] sm [0:3];

  always_ff @(posedge clk) begin
    if (en[SCS+3]) begin
      sm[0] <= tp[0] + tp[1];
      sm[1] <= tp[2] + tp[3];
      sm[2] <= tp[4] - tp[5];
      sm[3] <= tp[6] - tp[7];
    end
  end

  logic signed [15:0] qo [0:3];

  for (genvar c = 0; c < 4; c++) begin : g_fin
    logic signed [SW-1:0] rs;
    logic signed [SW-e2q_pkg::RSH-1:0] r;
    logic signed [15:0] sat;
    assign rs = (sm[c] + (SW'(1) <<< (e2q_pkg::RSH - 1))) >>> e2q_pkg::RSH;
    assign r = rs[SW-e2q_pkg::RSH-1:0];
    always_comb begin
      if (r > (SW-e2q_pkg::RSH)'(e2q_pkg::OUT_MAX)) begin
        sat = e2q_pkg::OUT_MAX;
      end else if (r < -(SW-e2q_pkg::RSH)'(e2q_pkg::OUT_MAX)) begin
        sat = -e2q_pkg::OUT_MAX;
      end else begin
        sat = r[15:0];
      end
    end
    always_ff @(posedge clk) begin
      if (en[SCS+4]) begin
        qo[c] <= sat;
      end
    end
  end

  assign quat_w = qo[0];
  assign quat_x = qo[1];
  assign quat_y = qo[2];
  assign quat_z = qo[3];

  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (vld[0] && res_valid && res_stall))
    else $error("request stalled while pipeline has room");
  a_no_min_value: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (quat_w != 16'sh8000 && quat_x != 16'sh8000 &&
                   quat_y != 16'sh8000 && quat_z != 16'sh8000))
    else $error("quaternion component outside saturation range");
endmodule
`default_nettype wire

/* tb/sv/tb_euler_to_quaternion_unit.sv */
// Testbench for the Euler-to-quaternion unit: directed and random requests checked against a bit-exact predictor.
`timescale 1ns / 1ps
module tb_euler_to_quaternion_unit;

  typedef struct packed {
    logic signed [17:0] pitch;
    logic signed [17:0] yaw;
    logic signed [17:0] roll;
  } angles_t;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic signed [17:0] pitch_deg = '0;
  logic signed [17:0] yaw_deg = '0;
  logic signed [17:0] roll_deg = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;

  angles_t pending_angles[$];
  quat_t expected_quats[$];
  int send_idle_pct = 25;
  int recv_idle_pct = 53;
  int hold_off_cycles = 0;
  bit pause_sender = 1'b0;
  bit req_taken = 1'b0;
  int errors = 0;
  int cycles = 0;

  euler_to_quaternion_unit u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .pitch_deg(pitch_deg), .yaw_deg(yaw_deg), .roll_deg(roll_deg),
    .res_valid(res_valid), .res_stall(res_stall),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_step(int i);
    longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772,
                      166886, 83443, 41722, 20861, 10430, 5215,
                      2608, 1304, 652, 326, 163, 81};
    return t[i];
  endfunction

  function automatic void half_angle_trig(input logic signed [17:0] a, output longint c,
                                          output longint s);
    longint av, x, y, z, dx, dy;
    logic [63:0] mag, den, ph64;
    logic [31:0] ph;
    bit flip;
    av = a;
    mag = (av < 0) ? -av : av;
    den = 64'd720 << 8;
    ph64 = ((mag << 32) + den / 2) / den;
    ph = ph64[31:0];
    flip = 1'b0;
    if (av < 0) ph = 32'd0 - ph;
    if (ph[31:30] == 2'd1 || ph[31:30] == 2'd2) begin
      ph = ph - 32'h8000_0000;
      flip = 1'b1;
    end
    z = ph[31] ? longint'(ph) - (64'sd1 <<< 32) : longint'(ph);
    x = 652032875;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    x = floor_sh(x + 512, 10);
    y = floor_sh(y + 512, 10);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic signed [15:0] round_sat(longint sum);
    longint r;
    r = floor_sh(sum + (64'sd1 <<< 44), 45);
    if (r > 32767) r = 32767;
    if (r < -32767) r = -32767;
    return r[15:0];
  endfunction

  function automatic quat_t angles_to_quat(angles_t a);
    longint cx, sx, cy, sy, cz, sz;
    quat_t q;
    half_angle_trig(a.pitch, cx, sx);
    half_angle_trig(a.yaw, cy, sy);
    half_angle_trig(a.roll, cz, sz);
    q.w = round_sat(cy * cx * cz + sy * sx * sz);
    q.x = round_sat(cy * sx * cz + sy * cx * sz);
    q.y = round_sat(sy * cx * cz - cy * sx * sz);
    q.z = round_sat(cy * cx * sz - sy * sx * cz);
    return q;
  endfunction

  function automatic logic signed [17:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 18'($signed($urandom_range(0, 184320)) - 92160);
      1: return 18'($signed($urandom_range(0, 512)) - 256);
      2: return 18'($signed($urandom_range(0, 8)) - 4 +
                    23040 * $signed($urandom_range(0, 8)) - 92160);
      3: return 18'($urandom);
      default: return 18'($signed($urandom_range(0, 184320)) - 92160);
    endcase
  endfunction

  task automatic add_request(int p, int y, int r);
    angles_t a;
    a.pitch = 18'(p); a.yaw = 18'(y); a.roll = 18'(r);
    pending_angles.push_back(a);
  endtask

  always @(posedge clk) begin
    req_taken <= !rst && req_valid && !req_stall;
  end

  // Driver: presents queued requests, holding the payload while stalled.
  always @(negedge clk) begin
    if (!rst) begin
      if (req_taken) begin
        expected_quats.push_back(angles_to_quat({pitch_deg, yaw_deg, roll_deg}));
        void'(pending_angles.pop_front());
      end
      if (!req_valid || req_taken) begin
        if (pending_angles.size() > 0 && !pause_sender &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          req_valid <= 1'b1;
          pitch_deg <= pending_angles[0].pitch;
          yaw_deg <= pending_angles[0].yaw;
          roll_deg <= pending_angles[0].roll;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // Monitor: checks every accepted result against the oldest prediction.
  always @(posedge clk) begin
    quat_t want;
    cycles <= cycles + 1;
    if (!rst && res_valid && !res_stall) begin
      if (expected_quats.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = expected_quats.pop_front();
        if (quat_w !== want.w) report_mismatch("quat_w", quat_w, want.w);
        if (quat_x !== want.x) report_mismatch("quat_x", quat_x, want.x);
        if (quat_y !== want.y) report_mismatch("quat_y", quat_y, want.y);
        if (quat_z !== want.z) report_mismatch("quat_z", quat_z, want.z);
      end
    end
  end

  initial begin
    wait (cycles >= LIMIT);
    $display("simulation failed");
    $finish;
  end

  task automatic drain();
    wait (pending_angles.size() == 0 && !req_valid && expected_quats.size() == 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    add_request(0, 0, 0);
    add_request(92160, 92160, 92160);
    add_request(-92160, -92160, -92160);
    add_request(131071, -131072, 0);
    add_request(-131072, 131071, -1);
    add_request(23040, 0, 0);
    add_request(0, 23040, 0);
    add_request(0, 0, 23040);
    add_request(46080, -46080, 46080);
    add_request(-23040, 69120, -69120);
    add_request(1, -1, 1);
    add_request(46079, 46081, 46080);
    add_request(-46080, -46079, -46081);
    add_request(23040, 23040, 23040);
    add_request(11520, -11520, 34560);
    add_request(-1, 0, 131071);
    for (int i = 0; i < 200; i++) add_request(rand_angle(), rand_angle(), rand_angle());
    drain();
    send_idle_pct = 53; recv_idle_pct = 25;
    for (int i = 0; i < 200; i++) add_request(rand_angle(), rand_angle(), rand_angle());
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    pause_sender = 1'b1;
    for (int i = 0; i < 200; i++) add_request(rand_angle(), rand_angle(), rand_angle());
    hold_off_cycles = 120;
    pause_sender = 1'b0;
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/e2q_pkg.sv
hw/rtl/e2q_sincos.sv
hw/rtl/euler_to_quaternion_unit.sv
tb/sv/tb_euler_to_quaternion_unit.sv
